>>> rtl/cwstm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwstm_pkg
// Shared widths, constants and tables for the Clohessy-Wiltshire transition
// matrix row generator.
// ----------------------------------------------------------------------------
package cwstm_pkg;

  localparam int CORDIC_STEPS_DEF = 32;
  localparam int RED_STEPS        = 14;
  localparam int Q_FRAC           = 24;
  localparam int DIV_BITS         = 49;
  localparam int DIV_LAT          = DIV_BITS + 2;
  localparam int AW               = 36;
  localparam int EW               = 48;
  localparam int NUM_W            = 51;
  localparam int MUL_W            = 37;

  localparam logic [0:0] REG_MEAN_MOTION = 1'b0;
  localparam logic [0:0] REG_TIME_STEP   = 1'b1;

  localparam logic [2:0] ROW_X  = 3'd0;
  localparam logic [2:0] ROW_Y  = 3'd1;
  localparam logic [2:0] ROW_Z  = 3'd2;
  localparam logic [2:0] ROW_VX = 3'd3;
  localparam logic [2:0] ROW_VY = 3'd4;
  localparam logic [2:0] ROW_VZ = 3'd5;

  localparam logic [31:0] MEAN_MOTION_RST = 32'd4724464;
  localparam logic [31:0] TIME_STEP_RST   = 32'd65536;

  localparam logic [63:0] TWO_PI_Q48 = 64'h0006487ED5110B46;

  localparam logic signed [AW-1:0] PI_Q32      = 36'sh3243F6A89;
  localparam logic signed [AW-1:0] HALF_PI_Q32 = 36'sh1921FB544;
  localparam logic signed [AW-1:0] GAIN_Q32    = 36'sh09B74EDA8;
  localparam logic signed [AW-1:0] ONE_Q32     = 36'sh100000000;

  localparam logic signed [EW-1:0] Q24_MAX = 48'sh7FFFFFFFFFFF;
  localparam logic signed [EW-1:0] Q24_MIN = 48'sh800000000000;
  localparam logic signed [EW-1:0] ONE_Q24 = 48'sh000001000000;

  // arctangent of 2^-i in Q32
  function automatic logic signed [AW-1:0] atan_q32(input int i);
    logic signed [AW-1:0] v;
    case (i)
      0:       v = 36'sd3373259426;
      1:       v = 36'sd1991351318;
      2:       v = 36'sd1052175346;
      3:       v = 36'sd534100635;
      4:       v = 36'sd268086748;
      5:       v = 36'sd134174063;
      6:       v = 36'sd67103404;
      7:       v = 36'sd33553749;
      8:       v = 36'sd16777131;
      9:       v = 36'sd8388597;
      10:      v = 36'sd4194303;
      default: v = (i <= 32) ? (36'sd1 <<< (32 - i)) : '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/cwstm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwstm_div
// Pipelined restoring divider: magnitude over mean motion, one quotient bit
// per stage, Q24 result truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module cwstm_div import cwstm_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] mag_i,
  input  logic             neg_i,
  input  logic [31:0]      den_i,
  output logic [EW-1:0]    quo_o,
  output logic             sat_o
);

  typedef struct packed {
    logic [NUM_W-1:0]    mag;
    logic                neg;
    logic [31:0]         den;
    logic                zero;
    logic                ovf;
    logic [31:0]         rem;
    logic [DIV_BITS-1:0] quo;
  } dst_t;

  localparam logic [DIV_BITS-1:0] POS_LIM = DIV_BITS'(Q24_MAX);
  localparam logic [DIV_BITS-1:0] NEG_LIM = DIV_BITS'(1) << (EW - 1);

  dst_t st_q [DIV_BITS+1];
  dst_t st0_d;

  logic [EW-1:0] quo_d, quo_q;
  logic          sat_d, sat_q;

  always_comb begin
    st0_d      = '0;
    st0_d.mag  = mag_i;
    st0_d.neg  = neg_i;
    st0_d.den  = den_i;
    st0_d.zero = (mag_i == '0);
    st0_d.ovf  = 32'(mag_i[NUM_W-1:DIV_BITS-Q_FRAC]) >= den_i;
    st0_d.rem  = 32'(mag_i[NUM_W-1:DIV_BITS-Q_FRAC]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_stage
    localparam int J = DIV_BITS - k;
    logic        nb;
    logic [32:0] rs, nr;
    logic        ge;
    dst_t        st_d;

    if (J >= Q_FRAC) begin : g_bit
      assign nb = st_q[k-1].mag[J-Q_FRAC];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign rs = {st_q[k-1].rem, nb};
    assign ge = rs >= {1'b0, st_q[k-1].den};
    assign nr = ge ? rs - {1'b0, st_q[k-1].den} : rs;

    always_comb begin
      st_d     = st_q[k-1];
      st_d.rem = nr[31:0];
      st_d.quo = {st_q[k-1].quo[DIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  always_comb begin
    quo_d = '0;
    sat_d = 1'b0;
    if (st_q[DIV_BITS].zero) begin
      quo_d = '0;
    end else if (st_q[DIV_BITS].ovf) begin
      sat_d = 1'b1;
      quo_d = st_q[DIV_BITS].neg ? Q24_MIN : Q24_MAX;
    end else if (!st_q[DIV_BITS].neg) begin
      if (st_q[DIV_BITS].quo > POS_LIM) begin
        sat_d = 1'b1;
        quo_d = Q24_MAX;
      end else begin
        quo_d = st_q[DIV_BITS].quo[EW-1:0];
      end
    end else begin
      if (st_q[DIV_BITS].quo > NEG_LIM) begin
        sat_d = 1'b1;
        quo_d = Q24_MIN;
      end else begin
        quo_d = EW'(0) - st_q[DIV_BITS].quo[EW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
      sat_q <= sat_d;
    end
  end

  assign quo_o = quo_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire

>>> rtl/cw_state_transition_matrix_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cw_state_transition_matrix_core
// One row of the 6x6 Clohessy-Wiltshire transition matrix per item, signed
// Q23.24 entries with saturation.
// ----------------------------------------------------------------------------
// The block takes one row request per clock and returns rows in order. Each
// item passes through a fixed pipeline of 70 + CORDIC_STEPS register stages
// (102 at the default), the output register included: the angle product, 14
// stages of modulo 2*pi reduction, a fold, one stage per CORDIC iteration, two
// stages of entry formation, 51 stages of a one-bit-per-stage divider with the
// n products alongside it, and the output register. Stalls at the output hold
// the pipeline only when its last stage is full; empty slots are squeezed out.
// Mean motion and time step are sampled when an item enters.
// ----------------------------------------------------------------------------
module cw_state_transition_matrix_core import cwstm_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [0:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    row_index_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    row_echo_o,
  output logic [EW-1:0] entry_col0_o,
  output logic [EW-1:0] entry_col1_o,
  output logic [EW-1:0] entry_col2_o,
  output logic [EW-1:0] entry_col3_o,
  output logic [EW-1:0] entry_col4_o,
  output logic [EW-1:0] entry_col5_o,
  output logic          saturated_flag_o
);

  localparam int NV = 2 + RED_STEPS + CORDIC_STEPS + 2 + DIV_LAT;
  localparam int WW = 54;
  localparam logic signed [WW-1:0] ONE_W = WW'(ONE_Q32);

  typedef struct packed {
    logic [2:0]  row;
    logic [31:0] n;
    logic [47:0] t32;
  } pass_t;

  typedef struct packed {
    logic [2:0]           row;
    logic [5:0][EW-1:0]   ent;
  } side_t;

  logic [31:0]   mm_q, ts_q;
  logic [NV-1:0] vld_q;
  logic          adv, load_out;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_q <= MEAN_MOTION_RST;
      ts_q <= TIME_STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MEAN_MOTION: mm_q <= cfg_data_i;
        REG_TIME_STEP:   ts_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign adv        = !vld_q[NV-1] || !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign load_out   = vld_q[NV-1] && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  // angle product
  logic [63:0] th_d, th_q;
  pass_t       s1p_q;

  assign th_d = mm_q * ts_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      th_q      <= th_d;
      s1p_q.row <= row_index_i;
      s1p_q.n   <= mm_q;
      s1p_q.t32 <= th_d[63:16];
    end
  end

  // modulo 2*pi reduction
  logic [63:0] red_q  [RED_STEPS];
  pass_t       redp_q [RED_STEPS];

  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    localparam logic [63:0] MODK = TWO_PI_Q48 << (RED_STEPS - 1 - k);
    logic [63:0] r_in, r_d;
    pass_t       p_in;

    if (k == 0) begin : g_first
      assign r_in = th_q;
      assign p_in = s1p_q;
    end else begin : g_next
      assign r_in = red_q[k-1];
      assign p_in = redp_q[k-1];
    end

    assign r_d = (r_in >= MODK) ? r_in - MODK : r_in;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        red_q[k]  <= r_d;
        redp_q[k] <= p_in;
      end
    end
  end

  // fold into the half circle
  logic signed [AW-1:0] a0, fa_d, fa_q;
  logic                 ffl_d, ffl_q;
  pass_t                fp_q;

  assign a0 = $signed({1'b0, red_q[RED_STEPS-1][50:16]});

  always_comb begin
    fa_d  = a0;
    ffl_d = 1'b0;
    if (fa_d > PI_Q32) begin
      fa_d = fa_d - (PI_Q32 <<< 1);
    end
    if (fa_d > HALF_PI_Q32) begin
      fa_d  = fa_d - PI_Q32;
      ffl_d = 1'b1;
    end else if (fa_d < -HALF_PI_Q32) begin
      fa_d  = fa_d + PI_Q32;
      ffl_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_q  <= fa_d;
      ffl_q <= ffl_d;
      fp_q  <= redp_q[RED_STEPS-1];
    end
  end

  // cordic rotation
  logic signed [AW-1:0] cx_q [CORDIC_STEPS];
  logic signed [AW-1:0] cy_q [CORDIC_STEPS];
  logic signed [AW-1:0] ca_q [CORDIC_STEPS];
  logic                 cfl_q [CORDIC_STEPS];
  pass_t                cp_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [AW-1:0] ATV = atan_q32(i);
    logic signed [AW-1:0] x_in, y_in, a_in, x_d, y_d, a_d;
    logic                 f_in;
    pass_t                p_in;

    if (i == 0) begin : g_first
      assign x_in = GAIN_Q32;
      assign y_in = '0;
      assign a_in = fa_q;
      assign f_in = ffl_q;
      assign p_in = fp_q;
    end else begin : g_next
      assign x_in = cx_q[i-1];
      assign y_in = cy_q[i-1];
      assign a_in = ca_q[i-1];
      assign f_in = cfl_q[i-1];
      assign p_in = cp_q[i-1];
    end

    assign x_d = a_in[AW-1] ? x_in + (y_in >>> i) : x_in - (y_in >>> i);
    assign y_d = a_in[AW-1] ? y_in - (x_in >>> i) : y_in + (x_in >>> i);
    assign a_d = a_in[AW-1] ? a_in + ATV : a_in - ATV;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[i]  <= x_d;
        cy_q[i]  <= y_d;
        ca_q[i]  <= a_d;
        cfl_q[i] <= f_in;
        cp_q[i]  <= p_in;
      end
    end
  end

  // sine and cosine
  logic signed [AW-1:0] sn_q, cs_q;
  pass_t                p1p_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sn_q  <= cfl_q[CORDIC_STEPS-1] ? -cy_q[CORDIC_STEPS-1] : cy_q[CORDIC_STEPS-1];
      cs_q  <= cfl_q[CORDIC_STEPS-1] ? -cx_q[CORDIC_STEPS-1] : cx_q[CORDIC_STEPS-1];
      p1p_q <= cp_q[CORDIC_STEPS-1];
    end
  end

  // entry formation
  logic signed [WW-1:0] s54, c54, t54;
  logic signed [WW-1:0] w00, w10, wc8, ws2, wsn2, wc4;
  logic signed [WW-1:0] mw, maw, aw, aaw, bw, abw;
  logic [5:0][EW-1:0]   ent_d;

  logic [5:0][EW-1:0] p2_ent_q;
  logic [2:0]         p2_row_q;
  logic [31:0]        p2_n_q;
  logic [MUL_W-1:0]   p2_mmag_q;
  logic               p2_mneg_q;
  logic [NUM_W-1:0]   p2_amag_q, p2_bmag_q;
  logic               p2_aneg_q, p2_bneg_q;

  assign s54 = WW'(sn_q);
  assign c54 = WW'(cs_q);
  assign t54 = $signed({6'b0, p1p_q.t32});

  assign w00  = (54'sd4 * ONE_W - 54'sd3 * c54) >>> 8;
  assign w10  = (54'sd6 * (s54 - t54)) >>> 8;
  assign wc8  = c54 >>> 8;
  assign ws2  = (54'sd2 * s54) >>> 8;
  assign wsn2 = (-54'sd2 * s54) >>> 8;
  assign wc4  = (54'sd4 * c54 - 54'sd3 * ONE_W) >>> 8;

  always_comb begin
    ent_d = '0;
    mw    = '0;
    aw    = '0;
    bw    = '0;
    case (p1p_q.row)
      ROW_X: begin
        ent_d[0] = w00[EW-1:0];
        aw       = s54;
        bw       = 54'sd2 * (ONE_W - c54);
      end
      ROW_Y: begin
        ent_d[0] = w10[EW-1:0];
        ent_d[1] = ONE_Q24;
        aw       = 54'sd2 * (c54 - ONE_W);
        bw       = 54'sd4 * s54 - 54'sd3 * t54;
      end
      ROW_Z: begin
        ent_d[2] = wc8[EW-1:0];
        aw       = s54;
      end
      ROW_VX: begin
        ent_d[3] = wc8[EW-1:0];
        ent_d[4] = ws2[EW-1:0];
        mw       = 54'sd3 * s54;
      end
      ROW_VY: begin
        ent_d[3] = wsn2[EW-1:0];
        ent_d[4] = wc4[EW-1:0];
        mw       = 54'sd6 * (c54 - ONE_W);
      end
      ROW_VZ: begin
        ent_d[5] = wc8[EW-1:0];
        mw       = -s54;
      end
      default: ;
    endcase
  end

  assign maw = mw[WW-1] ? -mw : mw;
  assign aaw = aw[WW-1] ? -aw : aw;
  assign abw = bw[WW-1] ? -bw : bw;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_ent_q  <= ent_d;
      p2_row_q  <= p1p_q.row;
      p2_n_q    <= p1p_q.n;
      p2_mmag_q <= maw[MUL_W-1:0];
      p2_mneg_q <= mw[WW-1];
      p2_amag_q <= aaw[NUM_W-1:0];
      p2_aneg_q <= aw[WW-1];
      p2_bmag_q <= abw[NUM_W-1:0];
      p2_bneg_q <= bw[WW-1];
    end
  end

  // quotients by n
  logic [EW-1:0] qa, qb;
  logic          sa, sb;

  cwstm_div u_div_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .mag_i (p2_amag_q),
    .neg_i (p2_aneg_q),
    .den_i (p2_n_q),
    .quo_o (qa),
    .sat_o (sa)
  );

  cwstm_div u_div_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .mag_i (p2_bmag_q),
    .neg_i (p2_bneg_q),
    .den_i (p2_n_q),
    .quo_o (qb),
    .sat_o (sb)
  );

  // products with n and side data alongside the divider
  side_t         side_q [DIV_LAT];
  side_t         side1_d;
  logic [52:0]   pph_q, msum;
  logic [47:0]   ppl_q;
  logic          mneg_q;
  logic [EW-1:0] mval;

  assign msum = pph_q + 53'(ppl_q >> 16);
  assign mval = mneg_q ? EW'(0) - EW'(msum[52:24]) : EW'(msum[52:24]);

  always_comb begin
    side1_d = side_q[0];
    case (side_q[0].row)
      ROW_VX:  side1_d.ent[0] = mval;
      ROW_VY:  side1_d.ent[0] = mval;
      ROW_VZ:  side1_d.ent[2] = mval;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pph_q      <= p2_n_q * p2_mmag_q[MUL_W-1:16];
      ppl_q      <= p2_n_q * p2_mmag_q[15:0];
      mneg_q     <= p2_mneg_q;
      side_q[0]  <= '{row: p2_row_q, ent: p2_ent_q};
      side_q[1]  <= side1_d;
    end
  end

  for (genvar k = 2; k < DIV_LAT; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // result assembly
  logic [5:0][EW-1:0] res_ent;
  logic               res_sat;
  logic [5:0][EW-1:0] out_ent_q;
  logic [2:0]         out_row_q;
  logic               out_sat_q;
  logic               out_valid_q;

  always_comb begin
    res_ent = side_q[DIV_LAT-1].ent;
    res_sat = 1'b0;
    case (side_q[DIV_LAT-1].row)
      ROW_X, ROW_Y: begin
        res_ent[3] = qa;
        res_ent[4] = qb;
        res_sat    = sa | sb;
      end
      ROW_Z: begin
        res_ent[5] = qa;
        res_sat    = sa;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_ent_q <= res_ent;
      out_row_q <= side_q[DIV_LAT-1].row;
      out_sat_q <= res_sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_echo_o       = out_row_q;
  assign entry_col0_o     = out_ent_q[0];
  assign entry_col1_o     = out_ent_q[1];
  assign entry_col2_o     = out_ent_q[2];
  assign entry_col3_o     = out_ent_q[3];
  assign entry_col4_o     = out_ent_q[4];
  assign entry_col5_o     = out_ent_q[5];
  assign saturated_flag_o = out_sat_q;

endmodule
`default_nettype wire
